// ===== hw/rtl/wwr_pkg.sv =====
// Shared types and constants for the whole-word replace stream block.
`default_nettype none
package wwr_pkg;

  localparam int unsigned WordMaxDef = 8;
  localparam int unsigned CharW      = 8;
  localparam int unsigned WordW      = 64;
  localparam int unsigned LenW       = 4;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CharW-1:0] SpaceChar = 8'd32;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTargetWord = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetLen  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReplWord   = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgReplLen    = 2'd3;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             run_last;
    logic             line_done;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic plan;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic plan_empty;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wwr_ctrl.sv =====
// Controller state machine sequencing accept, plan and emit phases.
`default_nettype none
module wwr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire wwr_pkg::dp_status_t status_i,
  output wwr_pkg::ctrl_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StPlan,
    StEmit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StPlan;
        end
      end
      StPlan: begin
        cmd_o.plan = 1'b1;
        state_d    = status_i.plan_empty ? StIdle : StEmit;
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wwr_datapath.sv =====
// Datapath: configuration, word buffer, match logic, emit counter and output register.
`default_nettype none
module wwr_datapath #(
  parameter int unsigned WORD_MAX = wwr_pkg::WordMaxDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [wwr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [wwr_pkg::WordW-1:0]     cfg_wdata_i,
  input  wire wwr_pkg::in_item_t             in_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output wwr_pkg::out_item_t                 out_data_o,
  input  wire wwr_pkg::ctrl_cmd_t            cmd_i,
  output wwr_pkg::dp_status_t                status_o
);

  localparam int unsigned FillW = $clog2(WORD_MAX + 1);
  localparam int unsigned CntW  = $clog2(WORD_MAX + 2);
  localparam int unsigned IdxW  = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
  localparam int unsigned CW    = wwr_pkg::CharW;

  // Configuration registers.
  logic [wwr_pkg::WordW-1:0] tw_q, rw_q;
  logic [wwr_pkg::LenW-1:0]  tl_q, rl_q;

  // Word buffer and word state.
  logic [CW-1:0]    store_q [WORD_MAX];
  logic [FillW-1:0] fill_q;
  logic             too_long_q;

  // Item latched at accept.
  logic [CW-1:0] ch_q;
  logic          eol_q, space_q, ovf_q, was_long_q;

  // Emit plan.
  logic [CntW-1:0] wcnt_q, total_q, k_q;
  logic            repl_q;

  logic              out_valid_q;
  wwr_pkg::out_item_t out_q;

  function automatic logic [FillW-1:0] clamp_len(input logic [wwr_pkg::LenW-1:0] len);
    logic [FillW-1:0] r;
    if (len == '0) begin
      r = FillW'(1);
    end else if (len > wwr_pkg::LenW'(WORD_MAX)) begin
      r = FillW'(WORD_MAX);
    end else begin
      r = FillW'(len);
    end
    return r;
  endfunction

  logic [FillW-1:0] tlen, rlen;
  logic             match;
  logic             is_space, can_store;
  logic             close_en;
  logic [CntW-1:0]  plan_wcnt, plan_total;
  logic             plan_repl, plan_extra;
  logic [IdxW-1:0]  k_idx;
  logic [CW-1:0]    emit_char;
  logic             emit_last;

  assign tlen = clamp_len(tl_q);
  assign rlen = clamp_len(rl_q);

  // Exact compare of the held word against the target, byte by byte.
  always_comb begin
    match = (fill_q == tlen);
    for (int i = 0; i < WORD_MAX; i++) begin
      if ((FillW'(i) < tlen) && (store_q[IdxW'(i)] != tw_q[CW*i +: CW])) begin
        match = 1'b0;
      end
    end
  end

  assign is_space  = (in_data_i.in_char == wwr_pkg::SpaceChar);
  assign can_store = !is_space && !too_long_q && (fill_q < FillW'(WORD_MAX));

  // A stored non-space character closes the word only at the end of the line.
  assign close_en = space_q || (eol_q && !was_long_q && !ovf_q);

  always_comb begin
    plan_wcnt = '0;
    plan_repl = 1'b0;
    if (ovf_q) begin
      plan_wcnt = CntW'(fill_q);
    end else if (close_en && !too_long_q && (fill_q != '0)) begin
      plan_repl = match;
      plan_wcnt = match ? CntW'(rlen) : CntW'(fill_q);
    end
    plan_extra = space_q || was_long_q || ovf_q;
    plan_total = plan_wcnt + CntW'(plan_extra);
  end

  assign k_idx     = k_q[IdxW-1:0];
  assign emit_last = ((k_q + CntW'(1)) == total_q);

  always_comb begin
    if (k_q < wcnt_q) begin
      emit_char = repl_q ? rw_q[CW*k_idx +: CW] : store_q[k_idx];
    end else begin
      emit_char = ch_q;
    end
  end

  assign status_o.plan_empty = (plan_total == '0);
  assign status_o.emit_last  = emit_last;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q       <= in_data_i.in_char;
      eol_q      <= in_data_i.end_of_line;
      space_q    <= is_space;
      was_long_q <= too_long_q;
      ovf_q      <= !is_space && !too_long_q && (fill_q >= FillW'(WORD_MAX));
      if (can_store) begin
        store_q[fill_q[IdxW-1:0]] <= in_data_i.in_char;
      end
    end
    if (cmd_i.plan) begin
      wcnt_q  <= plan_wcnt;
      total_q <= plan_total;
      repl_q  <= plan_repl;
    end
    if (cmd_i.emit) begin
      out_q.out_char  <= emit_char;
      out_q.run_last  <= emit_last;
      out_q.line_done <= emit_last && eol_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q        <= '0;
      rw_q        <= '0;
      tl_q        <= wwr_pkg::LenW'(1);
      rl_q        <= wwr_pkg::LenW'(1);
      fill_q      <= '0;
      too_long_q  <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wwr_pkg::CfgTargetWord: tw_q <= cfg_wdata_i;
          wwr_pkg::CfgTargetLen:  tl_q <= cfg_wdata_i[wwr_pkg::LenW-1:0];
          wwr_pkg::CfgReplWord:   rw_q <= cfg_wdata_i;
          wwr_pkg::CfgReplLen:    rl_q <= cfg_wdata_i[wwr_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && can_store) begin
        fill_q <= fill_q + FillW'(1);
      end
      // The plan is captured first, so the word state can be updated here.
      if (cmd_i.plan) begin
        k_q <= '0;
        if (eol_q || space_q) begin
          fill_q     <= '0;
          too_long_q <= 1'b0;
        end else if (ovf_q) begin
          fill_q     <= '0;
          too_long_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        k_q         <= k_q + CntW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/whole_word_replace_stream.sv =====
// Whole-word find and replace on a character stream, top level.
//
// Characters arrive on the input valid/ready channel, one per transfer, with
// end_of_line marking the last character of a line. Each space-delimited word
// is held in an internal buffer; when a space or the end of the line closes it,
// the word is compared with the configured target and either the replacement
// or the original word leaves on the output channel, followed by the space.
// Words longer than WORD_MAX characters are flushed and passed through.
// Each input character is accepted, then planned, and then its result characters
// (zero to WORD_MAX + 1) leave one by one, stepped by the single emit counter in
// the datapath. A registered output stage lets the next input transfer be taken
// while the last result still waits. When the receiver stalls, emission pauses
// and the output payload holds. Reset clears the word state and sets the target
// and replacement words to zero and both lengths to one. Configuration registers
// are written through the plain write port; the user must write them only while
// the block is idle, as the block itself does not enforce this.
`default_nettype none
module whole_word_replace_stream #(
  parameter int unsigned WORD_MAX = wwr_pkg::WordMaxDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [wwr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [wwr_pkg::WordW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire wwr_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output wwr_pkg::out_item_t               out_data_o
);

  wwr_pkg::ctrl_cmd_t  cmd;
  wwr_pkg::dp_status_t status;

  wwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wwr_datapath #(
    .WORD_MAX (WORD_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
`default_nettype wire
